// File: rtl/negdf_pkg.sv
// ----------------------------------------------------------------------------
// negdf_pkg
// shared constants and event codes of the packet deframer
// ----------------------------------------------------------------------------
package negdf_pkg;

  localparam int unsigned NEGDF_BUF_BYTES = 1024;
  localparam int unsigned NEGDF_HDR_LEN   = 4;

  localparam logic [7:0] NEGDF_START0 = 8'hff;
  localparam logic [7:0] NEGDF_START1 = 8'h01;
  localparam logic [7:0] NEGDF_START2 = 8'h7f;

  localparam int unsigned NEGDF_TDATA_W = 56;
  localparam int unsigned NEGDF_TUSER_W = 4;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_COMPLETE  = 3'd2,
    EV_ERROR     = 3'd3,
    EV_RELEASED  = 3'd4,
    EV_CLEARED   = 3'd5,
    EV_POLL_IDLE = 3'd6
  } event_e;

endpackage

// File: rtl/neg_encoded_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// neg_encoded_packet_deframer_unit
// radio receive deframer: start hunt, header, checked payload stream
// ----------------------------------------------------------------------------
// Every input word (radio byte or poll) yields exactly one result word, in the
// cycle after it is accepted. A new word is taken in every cycle the output
// side does not stall: the whole receiver update is one combinational step
// from the state registers into the result register, and the input side keeps
// running while the output side takes each result. Sustained rate is one word per
// cycle; ready drops only while a result is held back by the output side.
module neg_encoded_packet_deframer_unit #(
  parameter int unsigned BUF_BYTES = negdf_pkg::NEGDF_BUF_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,    // neg_encoding
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // rx_byte
  input  logic                                s_axis_tuser,   // func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // rx_state[3:0] data_byte[11:4] byte_index[21:12] pkt_type[29:22]
  // pkt_id[37:30] pkt_len[53:38] zero[55:54]
  output logic [negdf_pkg::NEGDF_TDATA_W-1:0] m_axis_tdata,
  // event_res[2:0] data_valid[3]
  output logic [negdf_pkg::NEGDF_TUSER_W-1:0] m_axis_tuser,
  output logic                                m_axis_tlast
);

  import negdf_pkg::*;

  localparam int unsigned POS_W = $clog2(BUF_BYTES + 1);

  typedef enum logic [3:0] {
    ST_READY   = 4'd0,
    ST_START1  = 4'd1,
    ST_START2  = 4'd2,
    ST_RAWHDR  = 4'd3,
    ST_HDR1    = 4'd4,
    ST_HDR2    = 4'd5,
    ST_RAWDATA = 4'd6,
    ST_DATA1   = 4'd7,
    ST_DATA2   = 4'd8,
    ST_ERROR   = 4'd9,
    ST_FULL    = 4'd10
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       held_q, held_d;
  logic [15:0]      len_q, len_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       id_q, id_d;
  logic             neg_q;

  logic             out_valid_q;
  event_e           ev_q, ev_d;
  logic [3:0]       state_q;
  logic             dv_q, dv_d;
  logic [7:0]       db_q, db_d;
  logic [9:0]       idx_q, idx_d;
  logic             last_q, last_d;
  logic [7:0]       otype_q;
  logic [7:0]       oid_q;
  logic [15:0]      olen_q;

  logic             in_acc;
  logic [7:0]       c;
  logic [7:0]       hdr_c;
  logic [7:0]       dat_c;
  logic [1:0]       hp;
  logic [15:0]      len_hdr;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] idx_w;
  logic             hdr_step;
  logic             dat_step;
  phase_e           hdr_next;
  phase_e           hdr_data;
  phase_e           dat_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;

  assign hp      = pos_q[1:0];
  assign pos_inc = pos_q + POS_W'(1);
  assign idx_w   = (pos_q >= POS_W'(NEGDF_HDR_LEN)) ? pos_q - POS_W'(NEGDF_HDR_LEN)
                                                    : '0;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    held_d   = held_q;
    len_d    = len_q;
    type_d   = type_q;
    id_d     = id_q;
    ev_d     = EV_NONE;
    dv_d     = 1'b0;
    db_d     = '0;
    idx_d    = '0;
    last_d   = 1'b0;
    hdr_step = 1'b0;
    dat_step = 1'b0;
    hdr_c    = c;
    dat_c    = c;
    hdr_next = ST_RAWHDR;
    hdr_data = ST_RAWDATA;
    dat_next = ST_RAWDATA;
    len_hdr  = len_q;

    if (s_axis_tuser) begin
      if (phase_q == ST_FULL) begin
        ev_d    = EV_RELEASED;
        pos_d   = '0;
        phase_d = ST_READY;
      end else if (phase_q == ST_ERROR) begin
        ev_d    = EV_CLEARED;
        pos_d   = '0;
        phase_d = ST_READY;
      end else begin
        ev_d = EV_POLL_IDLE;
      end
    end else begin
      case (phase_q)
        ST_ERROR, ST_FULL: begin
        end
        ST_READY: begin
          if (c == NEGDF_START0) begin
            phase_d = ST_START1;
            pos_d   = '0;
          end
        end
        ST_START1: phase_d = (c == NEGDF_START1) ? ST_START2 : ST_READY;
        ST_START2: begin
          if (c == NEGDF_START2) phase_d = neg_q ? ST_HDR1 : ST_RAWHDR;
          else phase_d = ST_READY;
        end
        ST_RAWHDR: hdr_step = 1'b1;
        ST_HDR1: begin
          held_d  = c;
          phase_d = ST_HDR2;
        end
        ST_HDR2: begin
          if (~c == held_q) begin
            hdr_step = 1'b1;
            hdr_c    = held_q;
            hdr_next = ST_HDR1;
            hdr_data = ST_DATA1;
          end else begin
            phase_d = ST_ERROR;
            ev_d    = EV_ERROR;
          end
        end
        ST_RAWDATA: dat_step = 1'b1;
        ST_DATA1: begin
          held_d  = c;
          phase_d = ST_DATA2;
        end
        ST_DATA2: begin
          if (~c == held_q) begin
            dat_step = 1'b1;
            dat_c    = held_q;
            dat_next = ST_DATA1;
          end else begin
            phase_d = ST_ERROR;
            ev_d    = EV_ERROR;
          end
        end
        default: begin
          phase_d = ST_READY;
          pos_d   = '0;
        end
      endcase
    end

    // header byte
    if (hdr_step) begin
      case (hp)
        2'd0:    type_d = hdr_c;
        2'd1:    id_d = hdr_c;
        2'd2:    len_hdr = {hdr_c, 8'h00};
        default: len_hdr = {len_q[15:8], hdr_c};
      endcase
      len_d = len_hdr;
      pos_d = POS_W'(hp) + POS_W'(1);
      if (hp != 2'd3) begin
        phase_d = hdr_next;
      end else if (len_hdr == 16'd0) begin
        phase_d = ST_FULL;
        ev_d    = EV_COMPLETE;
      end else begin
        phase_d = hdr_data;
      end
    end

    // payload byte
    if (dat_step) begin
      dv_d  = 1'b1;
      db_d  = dat_c;
      idx_d = 10'(idx_w);
      pos_d = pos_inc;
      if (17'(pos_inc) == 17'(len_q) + 17'(NEGDF_HDR_LEN)) begin
        last_d  = 1'b1;
        phase_d = ST_FULL;
        ev_d    = EV_COMPLETE;
      end else if (pos_inc >= POS_W'(BUF_BYTES)) begin
        phase_d = ST_ERROR;
        ev_d    = EV_ERROR;
      end else begin
        phase_d = dat_next;
        ev_d    = EV_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ST_READY;
      pos_q       <= '0;
      held_q      <= '0;
      len_q       <= '0;
      type_q      <= '0;
      id_q        <= '0;
      neg_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) neg_q <= cfg_wdata_i;
      if (in_acc) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        held_q      <= held_d;
        len_q       <= len_d;
        type_q      <= type_d;
        id_q        <= id_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q    <= ev_d;
      state_q <= phase_d;
      dv_q    <= dv_d;
      db_q    <= db_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      otype_q <= type_d;
      oid_q   <= id_d;
      olen_q  <= len_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, olen_q, oid_q, otype_q, idx_q, db_q, state_q};
  assign m_axis_tuser  = {dv_q, ev_q};
  assign m_axis_tlast  = last_q;

endmodule

// File: rtl/negdf_checker.sv
// ----------------------------------------------------------------------------
// negdf_checker
// port-level checks of the packet deframer, bound to the top level
// ----------------------------------------------------------------------------
module negdf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [negdf_pkg::NEGDF_TDATA_W-1:0] m_axis_tdata,
  input logic [negdf_pkg::NEGDF_TUSER_W-1:0] m_axis_tuser,
  input logic                                m_axis_tlast
);

  import negdf_pkg::*;

  logic       dv;
  logic [2:0] ev;

  assign dv = m_axis_tuser[3];
  assign ev = m_axis_tuser[2:0];

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // every accepted word gives a result next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // no payload fields without a payload byte
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !dv |->
      m_axis_tdata[21:4] == 18'd0 && !m_axis_tlast)
    else $error("payload fields set without data_valid");

  // last mark only on the completing payload byte
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> dv && ev == EV_COMPLETE)
    else $error("last mark outside packet completion");

  // payload byte only under payload, complete or overflow events
  a_dv_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dv |->
      (ev == EV_PAYLOAD || ev == EV_COMPLETE || ev == EV_ERROR))
    else $error("payload byte under wrong event");

endmodule

bind neg_encoded_packet_deframer_unit negdf_checker u_negdf_checker (.*);
